FILE: rtl/v4n_pkg.sv
//------------------------------------------------------------------------------
// v4n_pkg
// Shared register address and reset value for the four-component vector normalizer.
//------------------------------------------------------------------------------
`default_nettype none

package v4n_pkg;
	// register byte address (word index 0)
	localparam logic [0:0] REG_MIN_MAGNITUDE = 1'b0;

	// reset value of the length threshold
	localparam int MIN_MAG_RESET = 1;
endpackage

`default_nettype wire

FILE: rtl/vector4_normalize.sv
//------------------------------------------------------------------------------
// vector4_normalize
// Four-component fixed-point vector normalizer with a length threshold.
//------------------------------------------------------------------------------
// One result per item, one item per clock unless the output stalls.
// The pipeline has 2 + (CW+1) + (OF+2) register stages: absolute value
// and square, sum of squares, one stage per root bit of the square root
// (CW+1 bits), then one stage per quotient bit of the four restoring
// dividers (OF+2 bits). A stall freezes the whole pipeline. Outputs
// are formed from the last stage registers with no further register.
// The threshold is read when an item leaves the root stages.
`default_nettype none

module vector4_normalize #(
	parameter int COMPONENT_WIDTH      = 16,
	parameter int OUTPUT_FRACTION_BITS = 14
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [2:0]                       paddr,
	input  wire  [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire  signed [COMPONENT_WIDTH-1:0] comp_x,
	input  wire  signed [COMPONENT_WIDTH-1:0] comp_y,
	input  wire  signed [COMPONENT_WIDTH-1:0] comp_z,
	input  wire  signed [COMPONENT_WIDTH-1:0] comp_w,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic signed [OUTPUT_FRACTION_BITS+1:0] unit_x,
	output logic signed [OUTPUT_FRACTION_BITS+1:0] unit_y,
	output logic signed [OUTPUT_FRACTION_BITS+1:0] unit_z,
	output logic signed [OUTPUT_FRACTION_BITS+1:0] unit_w,
	output logic [COMPONENT_WIDTH:0]         length,
	output logic                             degenerate
);
	import v4n_pkg::*;

	localparam int CW = COMPONENT_WIDTH;
	localparam int OF = OUTPUT_FRACTION_BITS;
	localparam int MW = CW + 1;          // magnitude / length width
	localparam int SW = 2 * CW + 1;      // sum width
	localparam int RB = MW;              // root bits
	localparam int UW = OF + 2;          // unit width
	localparam int QB = OF + 2;          // quotient bits
	localparam int NW = MW + OF;         // shifted numerator width
	localparam int RW = MW + 1;          // partial remainder width

	logic [MW-1:0] min_mag_q;
	logic          adv;

	// pipeline advances unless the output is held
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign pready   = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mag_q <= MW'(MIN_MAG_RESET);
		end else if (psel && penable && pwrite && paddr[2] == REG_MIN_MAGNITUDE
				&& paddr[1:0] == 2'b00) begin
			min_mag_q <= pwdata[MW-1:0];
		end
	end
	assign prdata = (paddr[2] == REG_MIN_MAGNITUDE) ? 32'(min_mag_q) : 32'd0;

	// stage 1: magnitudes and squares
	logic [MW-1:0]   mag_s1 [4];
	logic [3:0]      neg_s1;
	logic [2*MW-1:0] sq_s1 [4];
	logic            v_s1;
	logic [CW-1:0]   cin [4];
	assign cin[0] = comp_x;
	assign cin[1] = comp_y;
	assign cin[2] = comp_z;
	assign cin[3] = comp_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				logic [MW-1:0] m;
				m = cin[i][CW-1] ? (MW'(0) - {cin[i][CW-1], cin[i]}) : {1'b0, cin[i]};
				mag_s1[i] <= m;
				neg_s1[i] <= cin[i][CW-1];
				sq_s1[i]  <= m * m;
			end
		end
	end

	// stage 2: sum of squares
	logic [MW-1:0] mag_s2 [4];
	logic [3:0]    neg_s2;
	logic [SW:0]   sum_s2;
	logic          v_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			sum_s2 <= (SW+1)'(sq_s1[0]) + (SW+1)'(sq_s1[1])
				+ (SW+1)'(sq_s1[2]) + (SW+1)'(sq_s1[3]);
		end
	end

	// square root stages: one root bit per stage, msb first
	logic [SW:0]   rem_r  [RB+1];
	logic [MW-1:0] root_r [RB+1];
	logic [MW-1:0] mag_r  [RB+1][4];
	logic [3:0]    neg_r  [RB+1];
	logic          v_r    [RB+1];
	assign rem_r[0]  = sum_s2;
	assign root_r[0] = '0;
	assign mag_r[0]  = mag_s2;
	assign neg_r[0]  = neg_s2;
	assign v_r[0]    = v_s2;

	for (genvar k = 0; k < RB; k++) begin : g_root
		localparam int B = RB - 1 - k;
		logic [SW+2:0] trial;
		logic          fit;
		// trial subtrahend (2*root + 2^B) * 2^B with lower bits of root clear
		assign trial = ((SW+3)'(root_r[k]) << (B + 1)) + ((SW+3)'(1) << (2 * B));
		assign fit   = (SW+3)'(rem_r[k]) >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_r[k+1] <= 1'b0;
			else if (adv) v_r[k+1] <= v_r[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_r[k+1]  <= fit ? (SW+1)'((SW+3)'(rem_r[k]) - trial) : rem_r[k];
				root_r[k+1] <= fit ? (root_r[k] | (MW'(1) << B)) : root_r[k];
				mag_r[k+1]  <= mag_r[k];
				neg_r[k+1]  <= neg_r[k];
			end
		end
	end

	// divider stages: restoring division, one quotient bit per stage
	logic [RW-1:0] prem_d [QB+1][4];
	logic [QB-1:0] quo_d  [QB+1][4];
	logic [NW-1:0] num_d  [QB+1][4];
	logic [MW-1:0] len_d  [QB+1];
	logic [3:0]    neg_d  [QB+1];
	logic          deg_d  [QB+1];
	logic          v_d    [QB+1];
	logic [MW-1:0] root_f;
	assign root_f = root_r[RB];
	assign len_d[0] = root_f;
	assign neg_d[0] = neg_r[RB];
	assign v_d[0]   = v_r[RB];
	assign deg_d[0] = (root_f == '0) || (root_f < min_mag_q);
	for (genvar i = 0; i < 4; i++) begin : g_dinit
		// numerator bits above the quotient bits; below the length since mag <= length
		assign prem_d[0][i] = RW'(mag_r[RB][i] >> (QB - OF));
		assign quo_d[0][i]  = '0;
		assign num_d[0][i]  = {mag_r[RB][i], OF'(0)};
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_d[k+1] <= 1'b0;
			else if (adv) v_d[k+1] <= v_d[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				len_d[k+1] <= len_d[k];
				neg_d[k+1] <= neg_d[k];
				deg_d[k+1] <= deg_d[k];
				for (int i = 0; i < 4; i++) begin
					logic [RW-1:0] sh;
					logic [RW:0]   df;
					// bring in numerator bit NW-1-(NW-QB)-k; upper bits preload
					sh = {prem_d[k][i][RW-2:0], num_d[k][i][QB-1-k]};
					df = {1'b0, sh} - {2'b00, len_d[k]};
					prem_d[k+1][i] <= df[RW] ? sh : df[RW-1:0];
					quo_d[k+1][i]  <= {quo_d[k][i][QB-2:0], ~df[RW]};
					num_d[k+1][i]  <= num_d[k][i];
				end
			end
		end
	end

	// output stage values
	logic [UW-1:0] unit_o [4];
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			logic [QB-1:0] q;
			q = (quo_d[QB][i] > QB'(1 << OF)) ? QB'(1 << OF) : quo_d[QB][i];
			if (deg_d[QB]) unit_o[i] = '0;
			else unit_o[i] = neg_d[QB][i] ? UW'(UW'(0) - q) : UW'(q);
		end
	end
	assign unit_x     = unit_o[0];
	assign unit_y     = unit_o[1];
	assign unit_z     = unit_o[2];
	assign unit_w     = unit_o[3];
	assign length     = len_d[QB];
	assign degenerate = deg_d[QB];
	assign out_valid  = v_d[QB];

`ifndef ASSERT_OFF
	// degenerate results carry the zero vector
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> unit_x == 0 && unit_y == 0 && unit_z == 0 && unit_w == 0)
		else $error("degenerate item with nonzero components");
	// a held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(length) && $stable(unit_x))
		else $error("stalled result changed");
	// zero length is always degenerate
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && length == 0 |-> degenerate)
		else $error("zero length not flagged");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_vector4_normalize.sv
//------------------------------------------------------------------------------
// tb_vector4_normalize
// Self-checking bench for the four-component vector normalizer: a directed
// pass over extreme vectors and threshold settings, then random vectors with
// random gaps on the input side and random stalls on the output side.
// Every result is checked field by field against an in-bench predictor.
//------------------------------------------------------------------------------
`default_nettype none

module tb_vector4_normalize;
	timeunit 1ns;
	timeprecision 1ps;
	import v4n_pkg::*;

	localparam int CW = 16;
	localparam int OF = 14;
	localparam int DRAIN_CYCLES = 3 + (CW + 1) + (OF + 2) + 8;

	typedef struct packed {
		logic [OF+1:0] ux;
		logic [OF+1:0] uy;
		logic [OF+1:0] uz;
		logic [OF+1:0] uw;
		logic [CW:0]   len;
		logic          degen;
	} unit_vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CW-1:0] comp_x = '0;
	logic signed [CW-1:0] comp_y = '0;
	logic signed [CW-1:0] comp_z = '0;
	logic signed [CW-1:0] comp_w = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OF+1:0] unit_x;
	logic signed [OF+1:0] unit_y;
	logic signed [OF+1:0] unit_z;
	logic signed [OF+1:0] unit_w;
	logic [CW:0] length;
	logic degenerate;

	// predictor copy of the threshold register
	logic [CW:0] threshold = (CW+1)'(MIN_MAG_RESET);
	unit_vec_t expected_units[$];
	int fail_count = 0;
	// no gaps and no stalls while set
	bit quiet = 1'b0;

	vector4_normalize uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z), .comp_w(comp_w),
		.out_valid(out_valid), .out_stall(out_stall),
		.unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z), .unit_w(unit_w),
		.length(length), .degenerate(degenerate)
	);

	always #4 clk = ~clk;

	// floor square root, bit by bit
	function automatic longint unsigned floor_sqrt(longint unsigned s);
		longint unsigned root;
		longint unsigned b;
		root = 0;
		b = 64'd1 << 62;
		while (b > s)
			b = b >> 2;
		while (b != 0) begin
			if (s >= root + b) begin
				s = s - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	// expected normalized vector for one input item
	function automatic unit_vec_t normalize_vec(logic signed [CW-1:0] c[4]);
		longint unsigned mag[4];
		longint unsigned sum;
		longint unsigned len;
		longint unsigned q;
		logic [OF+1:0] u[4];
		unit_vec_t r;
		sum = 0;
		for (int i = 0; i < 4; i++) begin
			mag[i] = (c[i] < 0) ? longint'(-int'(c[i])) : longint'(int'(c[i]));
			sum += mag[i] * mag[i];
		end
		len = floor_sqrt(sum);
		for (int i = 0; i < 4; i++) begin
			if (len == 0 || len < threshold) begin
				u[i] = '0;
			end else begin
				q = (mag[i] << OF) / len;
				if (q > (64'd1 << OF))
					q = 64'd1 << OF;
				u[i] = (c[i] < 0) ? (OF+2)'(-q) : (OF+2)'(q);
			end
		end
		r.ux = u[0];
		r.uy = u[1];
		r.uz = u[2];
		r.uw = u[3];
		r.len = (CW+1)'(len);
		r.degen = (len == 0 || len < threshold);
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// threshold write through the register port, block idle
	task automatic write_threshold(logic [CW:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {2'(REG_MIN_MAGNITUDE), 1'b0} << 1;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		threshold = value;
	endtask

	// send one item; valid stays high between back-to-back items
	task automatic send_vector(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
			logic signed [CW-1:0] z, logic signed [CW-1:0] w);
		int gap;
		logic signed [CW-1:0] c[4];
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		comp_x <= x;
		comp_y <= y;
		comp_z <= z;
		comp_w <= w;
		c = '{x, y, z, w};
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		expected_units.push_back(normalize_vec(c));
		@(posedge clk);
	endtask

	// drop valid and wait until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_units.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [CW-1:0] rand_comp(int mode);
		case (mode)
			0: return CW'($urandom);
			1: return CW'(int'($urandom_range(0, 16)) - 8);
			2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
			default: return CW'(int'($urandom_range(0, 600)) - 300);
		endcase
	endfunction

	task automatic test_directed();
		quiet = 1'b1;
		send_vector(0, 0, 0, 0);
		send_vector(1, 0, 0, 0);
		send_vector(0, -1, 0, 0);
		send_vector(3, 4, 0, 0);
		send_vector(0, 0, -3, 4);
		send_vector(16'sh7fff, 0, 0, 0);
		send_vector(0, 0, 0, 16'sh8000);
		send_vector(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_vector(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_vector(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
		send_vector(1, 1, 1, 1);
		send_vector(-1, -1, -1, -1);
		quiet = 1'b0;
		drain();
		// zero threshold: zero length still degenerate
		write_threshold(17'd0);
		send_vector(0, 0, 0, 0);
		send_vector(0, 0, 1, 0);
		drain();
		// top threshold: only the full-scale vector passes
		write_threshold(17'h10000);
		send_vector(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_vector(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_vector(16'sh8000, 0, 0, 0);
		drain();
		// threshold right at a length
		write_threshold(17'd5);
		send_vector(3, 4, 0, 0);
		send_vector(2, 4, 0, 0);
		send_vector(-2, -2, -2, -2);
		drain();
	endtask

	task automatic test_random(int count, logic [CW:0] thr);
		int mode;
		write_threshold(thr);
		for (int i = 0; i < count; i++) begin
			mode = $urandom_range(0, 3);
			quiet = (i % 150) < 20;
			send_vector(rand_comp(mode), rand_comp(mode), rand_comp(mode),
				($urandom_range(0, 5) == 0) ? 16'sd0 : rand_comp(mode));
		end
		quiet = 1'b0;
		drain();
	endtask

	// output stall: bursts of random length, some stretches with none
	initial begin
		int n;
		forever begin
			n = $urandom_range(1, 12);
			repeat (n) @(posedge clk);
			n = quiet ? 0 : pick_gap();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// result check, sampled before the accepting edge
	always @(negedge clk) begin
		unit_vec_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_units.size() == 0) begin
				$error("unexpected result, length %0d", length);
				fail_count++;
			end else begin
				e = expected_units.pop_front();
				if (unit_x !== e.ux) begin
					$error("unit_x expected %0d actual %0d", $signed(e.ux), unit_x);
					fail_count++;
				end
				if (unit_y !== e.uy) begin
					$error("unit_y expected %0d actual %0d", $signed(e.uy), unit_y);
					fail_count++;
				end
				if (unit_z !== e.uz) begin
					$error("unit_z expected %0d actual %0d", $signed(e.uz), unit_z);
					fail_count++;
				end
				if (unit_w !== e.uw) begin
					$error("unit_w expected %0d actual %0d", $signed(e.uw), unit_w);
					fail_count++;
				end
				if (length !== e.len) begin
					$error("length expected %0d actual %0d", e.len, length);
					fail_count++;
				end
				if (degenerate !== e.degen) begin
					$error("degenerate expected %0d actual %0d", e.degen, degenerate);
					fail_count++;
				end
			end
		end
	end

	// run limit
	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_random(500, 17'd1);
		test_random(350, 17'd0);
		test_random(350, 17'd9);
		test_random(300, 17'($urandom_range(100, 400)));
		test_random(200, 17'h10000);
		test_random(150, 17'($urandom_range(0, 65536)));
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

`default_nettype wire

FILE: files.f
rtl/v4n_pkg.sv
rtl/vector4_normalize.sv
bench/tb_vector4_normalize.sv
